### src/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared sizes and codes of the graph traversal block.
// ----------------------------------------------------------------------------
package gbt_pkg;

  // graph capacity
  localparam int VERTICES = 64;
  localparam int EDGES    = 256;

  // field widths
  localparam int VTX_W = 6;
  localparam int REQ_W = 3;
  localparam int ST_W  = 2;

  // derived sizes
  localparam int NV       = 2 ** VTX_W;
  localparam int EDGE_W   = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int CNT_W    = $clog2(EDGES + 1);
  localparam int WL_DEPTH = EDGES + 1;
  localparam int WL_A     = $clog2(WL_DEPTH);
  localparam int WL_W     = $clog2(WL_DEPTH + 1);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD_VTX  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_DIR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD_UND  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BFS      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DFS      = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_VISIT = 2'd0;
  localparam logic [ST_W-1:0] ST_OK    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

endpackage

### src/graph_bfs_dfs_traversal_top.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_top
// Directed graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
// Takes one request at a time. A request that gives only a status (vertex
// add, rejected add, unknown start) goes straight to the status state, and
// an edge add first does a tail read, an edge write and a link write per
// stored direction; both may wait in the status state for a free output
// register. A traversal pops worklist entries, reads the list head and tail
// of each visited vertex that has edges and scans its edges; the worklist,
// list and edge memories that the sequencer walks have a registered read
// port. Results leave through an output register, so a stalled result holds
// the sequencer only when a new one is due.
module graph_bfs_dfs_traversal_top
  import gbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [VTX_W-1:0] source_vertex_i,
  input  logic [VTX_W-1:0] dest_vertex_i,
  input  logic [VTX_W-1:0] start_vertex_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VTX_W-1:0] vertex_o,
  output logic [ST_W-1:0]  status_o,
  output logic             last_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_ADD_RD   = 10'b00_0000_0010,
    S_ADD_WR   = 10'b00_0000_0100,
    S_ADD_LINK = 10'b00_0000_1000,
    S_STAT     = 10'b00_0001_0000,
    S_POP      = 10'b00_0010_0000,
    S_POP_WAIT = 10'b00_0100_0000,
    S_LIST     = 10'b00_1000_0000,
    S_EDGE     = 10'b01_0000_0000,
    S_FIN      = 10'b10_0000_0000
  } state_e;

  localparam logic [VTX_W:0] VTX_LIM  = (VTX_W + 1)'(VERTICES);
  localparam logic [CNT_W:0] EDGE_LIM = (CNT_W + 1)'(EDGES);
  localparam logic [WL_W-1:0] WL_LIM  = WL_W'(WL_DEPTH);

  state_e state_q, state_d;

  logic [NV-1:0]     present_q, present_d;
  logic [NV-1:0]     nonempty_q, nonempty_d;
  logic [NV-1:0]     visited_q, visited_d;
  logic [CNT_W-1:0]  edge_cnt_q, edge_cnt_d;

  logic [VTX_W-1:0]  from_q, from_d;
  logic [VTX_W-1:0]  to_q, to_d;
  logic              second_q, second_d;
  logic              was_ne_q, was_ne_d;
  logic [EDGE_W-1:0] link_q, link_d;
  logic [EDGE_W-1:0] new_e_q, new_e_d;
  logic [ST_W-1:0]   stat_q, stat_d;

  logic              dfs_q, dfs_d;
  logic [WL_W-1:0]   rd_q, rd_d;
  logic [WL_W-1:0]   wr_q, wr_d;
  logic [WL_A-1:0]   wl_ra_q, wl_ra_d;
  logic [EDGE_W-1:0] e_q, e_d;
  logic [EDGE_W-1:0] tail_q, tail_d;
  logic [VTX_W-1:0]  pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;

  logic              out_valid_q, out_valid_d;
  logic [VTX_W-1:0]  out_vertex_q, out_vertex_d;
  logic [ST_W-1:0]   out_status_q, out_status_d;
  logic              out_last_q, out_last_d;
  logic              out_free;

  // memory ports
  logic              hd_we;
  logic [VTX_W-1:0]  hd_waddr, hd_raddr;
  logic [EDGE_W-1:0] hd_wdata, hd_rdata;
  logic              tl_we;
  logic [VTX_W-1:0]  tl_waddr, tl_raddr;
  logic [EDGE_W-1:0] tl_wdata, tl_rdata;
  logic              tg_we;
  logic [EDGE_W-1:0] tg_waddr, tg_raddr;
  logic [VTX_W-1:0]  tg_wdata, tg_rdata;
  logic              nx_we;
  logic [EDGE_W-1:0] nx_waddr, nx_raddr;
  logic [EDGE_W-1:0] nx_wdata, nx_rdata;
  logic              wl_we;
  logic [WL_A-1:0]   wl_waddr, wl_raddr;
  logic [VTX_W-1:0]  wl_wdata, wl_rdata;

  // edge list heads and tails, per vertex
  gbt_ram #(.WIDTH(EDGE_W), .DEPTH(NV)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata)
  );
  gbt_ram #(.WIDTH(EDGE_W), .DEPTH(NV)) u_tail (
    .clk_i, .we_i(tl_we), .waddr_i(tl_waddr), .wdata_i(tl_wdata),
    .raddr_i(tl_raddr), .rdata_o(tl_rdata)
  );

  // edge store
  gbt_ram #(.WIDTH(VTX_W), .DEPTH(EDGES)) u_target (
    .clk_i, .we_i(tg_we), .waddr_i(tg_waddr), .wdata_i(tg_wdata),
    .raddr_i(tg_raddr), .rdata_o(tg_rdata)
  );
  gbt_ram #(.WIDTH(EDGE_W), .DEPTH(EDGES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  // traversal worklist, fifo or stack
  gbt_ram #(.WIDTH(VTX_W), .DEPTH(WL_DEPTH)) u_work (
    .clk_i, .we_i(wl_we), .waddr_i(wl_waddr), .wdata_i(wl_wdata),
    .raddr_i(wl_raddr), .rdata_o(wl_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    logic [WL_A-1:0]  pop_addr;
    logic [CNT_W:0]   need_sum;
    logic             v_ok;
    logic             to_ok;
    logic [VTX_W-1:0] v;
    logic [VTX_W-1:0] to;

    state_d    = state_q;
    present_d  = present_q;
    nonempty_d = nonempty_q;
    visited_d  = visited_q;
    edge_cnt_d = edge_cnt_q;
    from_d     = from_q;
    to_d       = to_q;
    second_d   = second_q;
    was_ne_d   = was_ne_q;
    link_d     = link_q;
    new_e_d    = new_e_q;
    stat_d     = stat_q;
    dfs_d      = dfs_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    wl_ra_d    = wl_ra_q;
    e_d        = e_q;
    tail_d     = tail_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_vertex_d = out_vertex_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    hd_we = 1'b0; hd_waddr = from_q; hd_wdata = new_e_q;
    tl_we = 1'b0; tl_waddr = from_q; tl_wdata = new_e_q;
    tg_we = 1'b0; tg_waddr = new_e_q; tg_wdata = to_q;
    nx_we = 1'b0; nx_waddr = new_e_q; nx_wdata = '0;
    wl_we = 1'b0; wl_waddr = wr_q[WL_A-1:0]; wl_wdata = start_vertex_i;

    v        = wl_rdata;
    to       = tg_rdata;
    v_ok     = ({1'b0, v} < VTX_LIM);
    to_ok    = ({1'b0, to} < VTX_LIM);
    pop_addr = dfs_q ? WL_A'(wr_q - WL_W'(1)) : rd_q[WL_A-1:0];
    need_sum = {1'b0, edge_cnt_q} + ((req_type_i == REQ_ADD_UND) ? (CNT_W + 1)'(2)
                                                                  : (CNT_W + 1)'(1));

    wl_raddr = (state_q == S_POP) ? pop_addr : wl_ra_q;
    hd_raddr = v;
    tl_raddr = (state_q == S_ADD_RD) ? from_q : v;
    tg_raddr = (state_q == S_LIST) ? hd_rdata : nx_rdata;
    nx_raddr = tg_raddr;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (req_type_i)
            REQ_ADD_VTX: begin
              if ({1'b0, source_vertex_i} < VTX_LIM) begin
                present_d[source_vertex_i] = 1'b1;
                stat_d = ST_OK;
              end else begin
                stat_d = ST_BAD;
              end
              state_d = S_STAT;
            end
            REQ_ADD_DIR, REQ_ADD_UND: begin
              if (({1'b0, source_vertex_i} >= VTX_LIM) ||
                  ({1'b0, dest_vertex_i} >= VTX_LIM)) begin
                stat_d  = ST_BAD;
                state_d = S_STAT;
              end else if (need_sum > EDGE_LIM) begin
                stat_d  = ST_FULL;
                state_d = S_STAT;
              end else begin
                present_d[source_vertex_i] = 1'b1;
                present_d[dest_vertex_i]   = 1'b1;
                from_d   = source_vertex_i;
                to_d     = dest_vertex_i;
                second_d = (req_type_i == REQ_ADD_UND);
                state_d  = S_ADD_RD;
              end
            end
            REQ_BFS, REQ_DFS: begin
              if (({1'b0, start_vertex_i} >= VTX_LIM) ||
                  !present_q[start_vertex_i]) begin
                stat_d  = ST_BAD;
                state_d = S_STAT;
              end else begin
                visited_d  = '0;
                wl_we      = 1'b1;
                wl_waddr   = '0;
                wl_wdata   = start_vertex_i;
                wr_d       = WL_W'(1);
                rd_d       = '0;
                dfs_d      = (req_type_i == REQ_DFS);
                pend_vld_d = 1'b0;
                state_d    = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // tail of the source list is read here, valid in the next cycle
      S_ADD_RD: begin
        new_e_d = edge_cnt_q[EDGE_W-1:0];
        state_d = S_ADD_WR;
      end

      // store the edge and make it the list tail
      S_ADD_WR: begin
        tg_we    = 1'b1;
        nx_we    = 1'b1;
        tl_we    = 1'b1;
        hd_we    = !nonempty_q[from_q];
        was_ne_d = nonempty_q[from_q];
        link_d   = tl_rdata;
        nonempty_d[from_q] = 1'b1;
        edge_cnt_d = edge_cnt_q + CNT_W'(1);
        state_d  = S_ADD_LINK;
      end

      // chain the old tail to the new edge
      S_ADD_LINK: begin
        nx_we    = was_ne_q;
        nx_waddr = link_q;
        nx_wdata = new_e_q;
        if (second_q) begin
          second_d = 1'b0;
          from_d   = to_q;
          to_d     = from_q;
          state_d  = S_ADD_RD;
        end else begin
          stat_d  = ST_OK;
          state_d = S_STAT;
        end
      end

      S_STAT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = '0;
          out_status_d = stat_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      // take the next worklist entry
      S_POP: begin
        if (wr_q > rd_q) begin
          wl_ra_d = pop_addr;
          if (dfs_q) begin
            wr_d = wr_q - WL_W'(1);
          end else begin
            rd_d = rd_q + WL_W'(1);
          end
          state_d = S_POP_WAIT;
        end else begin
          state_d = S_FIN;
        end
      end

      // visit the popped vertex; the previous visit goes out now
      S_POP_WAIT: begin
        if (!v_ok || visited_q[v]) begin
          state_d = S_POP;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_valid_d  = 1'b1;
            out_vertex_d = pend_q;
            out_status_d = ST_VISIT;
            out_last_d   = 1'b0;
          end
          visited_d[v] = 1'b1;
          pend_d       = v;
          pend_vld_d   = 1'b1;
          state_d      = nonempty_q[v] ? S_LIST : S_POP;
        end
      end

      // head and tail of the list are in
      S_LIST: begin
        e_d     = hd_rdata;
        tail_d  = tl_rdata;
        state_d = S_EDGE;
      end

      // one edge per cycle
      S_EDGE: begin
        if (to_ok && !visited_q[to] && (wr_q < WL_LIM)) begin
          wl_we    = 1'b1;
          wl_waddr = wr_q[WL_A-1:0];
          wl_wdata = to;
          wr_d     = wr_q + WL_W'(1);
        end
        if (e_q == tail_q) begin
          state_d = S_POP;
        end else begin
          e_d = nx_rdata;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = pend_q;
          out_status_d = ST_VISIT;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      nonempty_q  <= '0;
      visited_q   <= '0;
      edge_cnt_q  <= '0;
      second_q    <= 1'b0;
      was_ne_q    <= 1'b0;
      dfs_q       <= 1'b0;
      rd_q        <= '0;
      wr_q        <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      nonempty_q  <= nonempty_d;
      visited_q   <= visited_d;
      edge_cnt_q  <= edge_cnt_d;
      second_q    <= second_d;
      was_ne_q    <= was_ne_d;
      dfs_q       <= dfs_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    from_q       <= from_d;
    to_q         <= to_d;
    link_q       <= link_d;
    new_e_q      <= new_e_d;
    stat_q       <= stat_d;
    wl_ra_q      <= wl_ra_d;
    e_q          <= e_d;
    tail_q       <= tail_d;
    pend_q       <= pend_d;
    out_vertex_q <= out_vertex_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, edge_cnt_q} <= EDGE_LIM)
    else $error("edge count beyond store size");

  a_wl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= WL_LIM)
    else $error("worklist overrun");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_VISIT) |-> last_o && (vertex_o == '0))
    else $error("status result not final or carries a vertex");

  a_fin_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> pend_vld_q)
    else $error("traversal ends with no visited vertex");

endmodule

### src/gbt_ram.sv
// ----------------------------------------------------------------------------
// gbt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### dv/graph_bfs_dfs_traversal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_checker
// Watches both channels, predicts every result of each accepted request from
// a private copy of the graph, and compares results in order.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_checker
  import gbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [REQ_W-1:0] req_type_i,
  input  logic [VTX_W-1:0] source_vertex_i,
  input  logic [VTX_W-1:0] dest_vertex_i,
  input  logic [VTX_W-1:0] start_vertex_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [VTX_W-1:0] vertex_i,
  input  logic [ST_W-1:0]  status_i,
  input  logic             last_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [ST_W-1:0]  status;
    logic             last;
  } result_t;

  result_t result_q[$];

  // private copy of the graph
  logic             present[VERTICES];
  logic             has_list[VERTICES];
  int               head[VERTICES];
  int               tail[VERTICES];
  logic [VTX_W-1:0] target[EDGES];
  int               next_edge[EDGES];
  int               n_edges;

  assign pending_o = result_q.size();

  function automatic void push_status(logic [ST_W-1:0] st);
    result_t r;
    r.vertex = '0;
    r.status = st;
    r.last   = 1'b1;
    result_q = {result_q, r};
  endfunction

  function automatic void link_edge(int from, int to);
    target[n_edges] = to[VTX_W-1:0];
    next_edge[n_edges] = 0;
    if (has_list[from]) next_edge[tail[from]] = n_edges;
    else begin
      head[from] = n_edges;
      has_list[from] = 1'b1;
    end
    tail[from] = n_edges;
    n_edges++;
  endfunction

  // predict the visit order of one traversal
  function automatic void predict_walk(int start, bit depth_first);
    logic  seen[VERTICES];
    int    work[$];
    int    v;
    int    e;
    int    steps;
    int    n;
    result_t r;
    n = 0;
    if (start >= VERTICES || !present[start]) begin
      push_status(ST_BAD);
      return;
    end
    foreach (seen[i]) seen[i] = 1'b0;
    work = {work, start};
    while (work.size() > 0) begin
      if (depth_first) v = work.pop_back();
      else v = work.pop_front();
      if (seen[v]) continue;
      seen[v] = 1'b1;
      r.vertex = v[VTX_W-1:0];
      r.status = ST_VISIT;
      r.last   = 1'b0;
      result_q = {result_q, r};
      n++;
      if (has_list[v]) begin
        e = head[v];
        steps = 0;
        while (steps < n_edges) begin
          if (!seen[target[e]]) work = {work, int'(target[e])};
          if (e == tail[v]) break;
          e = next_edge[e];
          steps++;
        end
      end
    end
    if (n > 0) result_q[result_q.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_request(logic [REQ_W-1:0] req, int src, int dst,
                                          int start);
    int need;
    case (req)
      REQ_ADD_VTX: begin
        present[src] = 1'b1;
        push_status(ST_OK);
      end
      REQ_ADD_DIR, REQ_ADD_UND: begin
        need = (req == REQ_ADD_DIR) ? 1 : 2;
        if (EDGES - n_edges < need) push_status(ST_FULL);
        else begin
          present[src] = 1'b1;
          present[dst] = 1'b1;
          link_edge(src, dst);
          if (need == 2) link_edge(dst, src);
          push_status(ST_OK);
        end
      end
      REQ_BFS: predict_walk(start, 1'b0);
      REQ_DFS: predict_walk(start, 1'b1);
      default: ;
    endcase
  endfunction

  // predict on input transfers, compare on output transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
      result_q.delete();
      n_edges = 0;
      foreach (present[i]) begin
        present[i]  = 1'b0;
        has_list[i] = 1'b0;
      end
    end else begin
      if (in_valid_i && !in_stall_i)
        predict_request(req_type_i, int'(source_vertex_i), int'(dest_vertex_i),
                        int'(start_vertex_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result: vertex %0d status %0d last %0d",
                     vertex_i, status_i, last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.vertex !== vertex_i || exp_r.status !== status_i ||
              exp_r.last !== last_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected vertex %0d status %0d last %0d, got %0d %0d %0d",
                       exp_r.vertex, exp_r.status, exp_r.last,
                       vertex_i, status_i, last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_graph_bfs_dfs_traversal_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_bfs_dfs_traversal_top
// Builds graphs through add requests, runs breadth-first and depth-first
// walks with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_graph_bfs_dfs_traversal_top;
  import gbt_pkg::*;

  localparam int WATCHDOG = 20000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [REQ_W-1:0] req_type_i = '0;
  logic [VTX_W-1:0] source_vertex_i = '0;
  logic [VTX_W-1:0] dest_vertex_i = '0;
  logic [VTX_W-1:0] start_vertex_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [VTX_W-1:0] vertex_o;
  logic [ST_W-1:0]  status_o;
  logic             last_o;
  int               fail_count;
  int               pending;
  int               quiet_cycles = 0;
  logic             known[VERTICES];

  always #4 clk_i = ~clk_i;

  graph_bfs_dfs_traversal_top DUT (.*);

  graph_bfs_dfs_traversal_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i,
    .source_vertex_i, .dest_vertex_i, .start_vertex_i,
    .out_valid_i(out_valid_o), .out_stall_i, .vertex_i(vertex_o),
    .status_i(status_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random receiver stall, drawn per result
  initial begin
    int gap;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // one request transfer, after a random gap when gaps is set; valid stays up for a gapless follower
  task automatic send_req(logic [REQ_W-1:0] req, int src, int dst, int start, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    source_vertex_i <= src[VTX_W-1:0];
    dest_vertex_i   <= dst[VTX_W-1:0];
    start_vertex_i  <= start[VTX_W-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req <= REQ_ADD_UND) begin
      known[src] = 1'b1;
      if (req != REQ_ADD_VTX) known[dst] = 1'b1;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic int pick_known();
    int v;
    v = $urandom_range(0, VERTICES - 1);
    for (int i = 0; i < VERTICES; i++)
      if (known[(v + i) % VERTICES]) return (v + i) % VERTICES;
    return v;
  endfunction

  initial begin
    int kind;
    int src;
    foreach (known[i]) known[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown start, extremes, self loop, repeated edge, bad codes
    send_req(REQ_BFS, 0, 0, 0, 1'b0);
    send_req(REQ_DFS, 63, 63, 63, 1'b0);
    send_req(REQ_ADD_VTX, 0, 0, 0, 1'b0);
    send_req(REQ_ADD_VTX, 63, 0, 0, 1'b0);
    send_req(REQ_BFS, 0, 0, 0, 1'b0);
    send_req(REQ_ADD_DIR, 0, 63, 0, 1'b1);
    send_req(REQ_ADD_DIR, 0, 0, 0, 1'b1);
    send_req(REQ_ADD_DIR, 0, 63, 0, 1'b1);
    send_req(REQ_ADD_UND, 63, 21, 42, 1'b1);
    send_req(REQ_ADD_UND, 42, 21, 0, 1'b1);
    send_req(REQ_BFS, 0, 0, 0, 1'b1);
    send_req(REQ_DFS, 0, 0, 0, 1'b1);
    send_req(REQ_DFS, 21, 42, 63, 1'b1);
    send_req(3'd5, 63, 63, 63, 1'b1);
    send_req(3'd6, 0, 0, 0, 1'b1);
    send_req(3'd7, 42, 21, 63, 1'b1);
    send_req(REQ_BFS, 42, 21, 21, 1'b1);
    drain();

    // random: mostly graph building and walks from present vertices
    for (int n = 0; n < 40; n++) begin
      kind = $urandom_range(0, 19);
      src = $urandom_range(0, VERTICES - 1);
      if (kind < 2) send_req(REQ_ADD_VTX, src, 0, $urandom_range(0, 63), 1'b1);
      else if (kind < 7)
        send_req(REQ_ADD_DIR, src, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
      else if (kind < 12)
        send_req(REQ_ADD_UND, src, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
      else if (kind < 18)
        send_req((kind < 15) ? REQ_BFS : REQ_DFS, src, $urandom_range(0, 63),
                 ($urandom_range(0, 4) == 0) ? src : pick_known(), 1'b1);
      else if (kind == 18)
        send_req(3'($urandom_range(5, 7)), src, $urandom_range(0, 63), src, 1'b1);
      else drain();
    end

    // grow a denser graph back to back, then walk it
    for (int n = 0; n < 36; n++)
      send_req(REQ_ADD_UND, $urandom_range(0, 63), $urandom_range(0, 63), 0, 1'b0);
    send_req(REQ_ADD_DIR, 1, 2, 0, 1'b0);
    send_req(REQ_ADD_UND, 3, 4, 0, 1'b0);
    send_req(REQ_BFS, 0, 0, 0, 1'b1);
    send_req(REQ_DFS, 0, 0, 63, 1'b1);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
